[src/eight_bit_accumulator_cpu_defines.svh]
// Assertion macros for the checker file of the accumulator core.
`ifndef EIGHT_BIT_ACCUMULATOR_CPU_DEFINES_SVH
`define EIGHT_BIT_ACCUMULATOR_CPU_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EBAC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EBAC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ebac_pkg.sv]
// Shared types and constants of the accumulator core.
package ebac_pkg;
	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NUM_REGS  = 16;

	localparam logic [1:0] OP_EXEC  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SETPC = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [3:0]  ext_flags;
		logic [7:0]  in_port;
	} cmd_t;

	typedef struct packed {
		logic [7:0] instr;
		logic       idle;
		logic       q_pin;
		logic       port_valid;
		logic [2:0] port_num;
		logic [7:0] port_data;
		logic       int_enable;
	} rsp_t;
endpackage

[src/eight_bit_accumulator_cpu.sv]
// Accumulator core: memory write, set-counter and idle items answer in the cycle after accept.
// An instruction passes fetch, decode and operand states, an execute state for a memory operand
// and a long-branch state for a taken long branch; the next item is taken as the result leaves.
// The states are set by the single byte-memory port: fetch, operand and second branch byte.
// Reset clears all control and flags; registers read zero until written; memory stays unknown.
module eight_bit_accumulator_cpu import ebac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_OPR   = 3'd3;
	localparam logic [2:0] S_EXE   = 3'd4;
	localparam logic [2:0] S_LBR   = 3'd5;

	logic [2:0]  state_q;
	logic [7:0]  d_q, t_q, opc_q, h_q, inb_q;
	logic        df_q, ie_q, q_q, idle_q;
	logic [3:0]  p_q, x_q, ef_q;
	logic [15:0] pc_q;
	logic        rsp_valid_q;
	logic [7:0]  instr_q, pd_q;
	logic        pv_q;
	logic [2:0]  pn_q;

	logic              mem_en, mem_we;
	logic [15:0]       mem_addr16;
	logic [7:0]        mem_wdata, mem_rdata;
	logic [3:0]        rf_raddr, rf_waddr;
	logic [15:0]       rf_rdata, rf_wdata;
	logic              rf_we;

	logic        slot_free, accept, finish;
	logic [3:0]  hi, n;
	logic [15:0] r, opa;
	logic        cond3, condc;
	logic        is_imm, rx_rd, lb_form, lb_go, pc_rd, need_exe, skip_pc2;
	logic        out_op, shift_op, alu_op, load_op;
	logic [7:0]  alu_d;
	logic        alu_df;
	logic [3:0]  dec_hi;

	function automatic logic test_cond(input logic [2:0] s, input logic [3:0] ef,
		input logic q, input logic [7:0] d, input logic df);
		logic res;
		case (s)
			3'd0:    res = 1'b1;
			3'd1:    res = q;
			3'd2:    res = (d == 8'h00);
			3'd3:    res = df;
			default: res = ef[s[1:0]];
		endcase
		return res;
	endfunction

	ebac_memory u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr16[MEM_AW-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	ebac_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (rf_raddr),
		.rdata  (rf_rdata),
		.we     (rf_we),
		.waddr  (rf_waddr),
		.wdata  (rf_wdata)
	);

	ebac_alu u_alu (
		.opc   (opc_q),
		.d     (d_q),
		.m     (mem_rdata),
		.df    (df_q),
		.d_nx  (alu_d),
		.df_nx (alu_df)
	);

	// take a new item only with no item in flight and room for its result
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == S_IDLE) && slot_free;
	assign accept    = cmd_valid && cmd_ready;

	// decode of the latched opcode
	assign hi     = opc_q[7:4];
	assign n      = opc_q[3:0];
	assign r      = rf_rdata;
	assign opa    = pc_q - 16'd1;
	assign dec_hi = mem_rdata[7:4];
	assign cond3  = test_cond(n[2:0], ef_q, q_q, d_q, df_q);
	assign condc  = test_cond({1'b0, n[1:0]}, ef_q, q_q, d_q, df_q);

	assign is_imm  = ((hi == 4'h7) && (n == 4'hC || n == 4'hD || n == 4'hF)) ||
		((hi == 4'hF) && n[3] && (n != 4'hE));
	assign rx_rd   = ((hi == 4'h0) && (n != 4'h0)) || (hi == 4'h4) ||
		((hi == 4'h6) && !n[3] && (n != 4'h0)) ||
		((hi == 4'h7) && (n == 4'h0 || n == 4'h1 || n == 4'h2 || n == 4'h4 ||
			n == 4'h5 || n == 4'h7)) ||
		((hi == 4'hF) && !n[3] && (n != 4'h6));
	assign lb_form = (hi == 4'hC) && !n[2];
	assign lb_go   = lb_form && (condc ^ n[3]);
	assign pc_rd   = (hi == 4'h3) || is_imm || lb_go;
	assign need_exe = rx_rd || pc_rd;
	assign skip_pc2 = (hi == 4'hC) && !lb_go && (lb_form ||
		((n == 4'h5 || n == 4'h6 || n == 4'h7) && !condc) ||
		((n == 4'hC) && ie_q) ||
		((n == 4'hD || n == 4'hE || n == 4'hF) && condc));
	assign out_op   = (hi == 4'h6) && !n[3] && (n != 4'h0);
	assign shift_op = ((hi == 4'h7) || (hi == 4'hF)) && (n[2:0] == 3'd6);
	assign alu_op   = ((hi == 4'h7) && (n[2] || (n == 4'h4))) || (hi == 4'hF);
	assign load_op  = (hi == 4'h0) || (hi == 4'h4) || ((hi == 4'h7) && (n == 4'h2));

	// an item finishes here: a non-executing item at accept, an instruction in its last state
	assign finish = ((state_q == S_IDLE) && accept && !(cmd.op == OP_EXEC && !idle_q)) ||
		((state_q == S_OPR) && !need_exe) ||
		((state_q == S_EXE) && !lb_go) ||
		(state_q == S_LBR);

	// memory and register-file port control
	always_comb begin
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		mem_addr16 = pc_q;
		mem_wdata  = d_q;
		rf_raddr   = p_q;
		rf_we      = 1'b0;
		rf_waddr   = p_q;
		rf_wdata   = pc_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.op == OP_WRITE) begin
					mem_en     = 1'b1;
					mem_we     = 1'b1;
					mem_addr16 = cmd.addr;
					mem_wdata  = cmd.wdata;
				end
				if (accept && cmd.op == OP_SETPC) begin
					rf_we    = 1'b1;
					rf_wdata = cmd.addr;
				end
			end
			S_FETCH: begin
				// fetch the opcode and advance R(P)
				mem_en     = 1'b1;
				mem_addr16 = rf_rdata;
				rf_we      = 1'b1;
				rf_wdata   = rf_rdata + 16'd1;
			end
			S_DEC: begin
				if (dec_hi == 4'h6 || dec_hi == 4'h7 || dec_hi == 4'hF) begin
					rf_raddr = x_q;
				end else begin
					rf_raddr = mem_rdata[3:0];
				end
			end
			S_OPR: begin
				if (need_exe) begin
					mem_en     = 1'b1;
					mem_addr16 = pc_rd ? pc_q : r;
				end
				// stores
				if (hi == 4'h5) begin
					mem_en = 1'b1; mem_we = 1'b1; mem_addr16 = r; mem_wdata = d_q;
				end
				if (hi == 4'h6 && n[3] && n != 4'h8) begin
					mem_en = 1'b1; mem_we = 1'b1; mem_addr16 = r; mem_wdata = inb_q;
				end
				if (hi == 4'h7 && n == 4'h3) begin
					mem_en = 1'b1; mem_we = 1'b1; mem_addr16 = r; mem_wdata = d_q;
				end
				if (hi == 4'h7 && n == 4'h8) begin
					mem_en = 1'b1; mem_we = 1'b1; mem_addr16 = r; mem_wdata = t_q;
				end
				// register updates
				case (hi)
					4'h1: begin rf_we = 1'b1; rf_waddr = n; rf_wdata = r + 16'd1; end
					4'h2: begin rf_we = 1'b1; rf_waddr = n; rf_wdata = r - 16'd1; end
					4'h4: begin rf_we = 1'b1; rf_waddr = n; rf_wdata = r + 16'd1; end
					4'h6: begin
						if (!n[3]) begin
							rf_we = 1'b1; rf_waddr = x_q; rf_wdata = r + 16'd1;
						end
					end
					4'h7: begin
						if (n == 4'h0 || n == 4'h1 || n == 4'h2) begin
							rf_we = 1'b1; rf_waddr = x_q; rf_wdata = r + 16'd1;
						end else if (n == 4'h3) begin
							rf_we = 1'b1; rf_waddr = x_q; rf_wdata = r - 16'd1;
						end
					end
					4'hA: begin rf_we = 1'b1; rf_waddr = n; rf_wdata = {r[15:8], d_q}; end
					4'hB: begin rf_we = 1'b1; rf_waddr = n; rf_wdata = {d_q, r[7:0]}; end
					4'hC: begin
						if (skip_pc2) begin
							rf_we = 1'b1; rf_wdata = pc_q + 16'd2;
						end
					end
					default: rf_we = 1'b0;
				endcase
				if (is_imm) begin
					rf_we    = 1'b1;
					rf_waddr = p_q;
					rf_wdata = pc_q + 16'd1;
				end
			end
			S_EXE: begin
				if (lb_go) begin
					mem_en     = 1'b1;
					mem_addr16 = pc_q + 16'd1;
				end
				if (hi == 4'h3) begin
					rf_we    = 1'b1;
					rf_wdata = (cond3 ^ n[3]) ? {opa[15:8], mem_rdata} : pc_q + 16'd1;
				end
			end
			S_LBR: begin
				rf_we    = 1'b1;
				rf_wdata = {h_q, mem_rdata};
			end
			default: rf_we = 1'b0;
		endcase
	end

	// sequencer and processor flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			d_q         <= 8'h00;
			df_q        <= 1'b0;
			t_q         <= 8'h00;
			p_q         <= 4'h0;
			x_q         <= 4'h0;
			ie_q        <= 1'b0;
			q_q         <= 1'b0;
			idle_q      <= 1'b0;
			pc_q        <= 16'h0000;
			opc_q       <= 8'h00;
		end else begin
			// hold the result until taken; load it as an item finishes
			rsp_valid_q <= finish || (rsp_valid_q && !rsp_ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.op == OP_EXEC && !idle_q) begin
							state_q <= S_FETCH;
						end
						if (cmd.op == OP_SETPC) begin
							idle_q <= 1'b0;
						end
					end
				end
				S_FETCH: begin
					pc_q    <= rf_rdata + 16'd1;
					state_q <= S_DEC;
				end
				S_DEC: begin
					opc_q   <= mem_rdata;
					state_q <= S_OPR;
				end
				S_OPR: begin
					if (need_exe) begin
						state_q <= S_EXE;
					end else begin
						state_q <= S_IDLE;
					end
					if (hi == 4'h0 && n == 4'h0) begin
						idle_q <= 1'b1;
					end
					if (hi == 4'h6 && n[3] && n != 4'h8) begin
						d_q <= inb_q;
					end
					if (hi == 4'h7 && n == 4'h9) begin
						t_q <= {x_q, p_q};
					end
					if (hi == 4'h7 && n == 4'hA) begin
						q_q <= 1'b0;
					end
					if (hi == 4'h7 && n == 4'hB) begin
						q_q <= 1'b1;
					end
					if (shift_op) begin
						d_q  <= alu_d;
						df_q <= alu_df;
					end
					if (hi == 4'h8) begin
						d_q <= r[7:0];
					end
					if (hi == 4'h9) begin
						d_q <= r[15:8];
					end
					if (hi == 4'hD) begin
						p_q <= n;
					end
					if (hi == 4'hE) begin
						x_q <= n;
					end
				end
				S_EXE: begin
					if (lb_go) begin
						state_q <= S_LBR;
					end else begin
						state_q <= S_IDLE;
					end
					if (load_op) begin
						d_q <= mem_rdata;
					end
					if (alu_op && !shift_op) begin
						d_q  <= alu_d;
						df_q <= alu_df;
					end
					// RET and DIS
					if (hi == 4'h7 && (n == 4'h0 || n == 4'h1)) begin
						x_q  <= mem_rdata[7:4];
						p_q  <= mem_rdata[3:0];
						ie_q <= !n[0];
					end
				end
				S_LBR: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			ef_q    <= cmd.ext_flags;
			inb_q   <= cmd.in_port;
			instr_q <= 8'h00;
			pv_q    <= 1'b0;
			pn_q    <= 3'd0;
			pd_q    <= 8'h00;
		end
		if (state_q == S_OPR) begin
			instr_q <= opc_q;
		end
		if (state_q == S_EXE && lb_go) begin
			h_q <= mem_rdata;
		end
		if (state_q == S_EXE && out_op) begin
			pv_q <= 1'b1;
			pn_q <= n[2:0];
			pd_q <= mem_rdata;
		end
	end

	// flags are stable while a result waits: no item runs until it is taken
	always_comb begin
		rsp.instr      = instr_q;
		rsp.idle       = idle_q;
		rsp.q_pin      = q_q;
		rsp.port_valid = pv_q;
		rsp.port_num   = pn_q;
		rsp.port_data  = pd_q;
		rsp.int_enable = ie_q;
	end

	assign rsp_valid = rsp_valid_q;
endmodule

[src/ebac_memory.sv]
// Byte memory, one port, registered read data.
module ebac_memory import ebac_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [MEM_AW-1:0] addr,
	input  logic [7:0]        wdata,
	output logic [7:0]        rdata
);
	logic [7:0] mem_q [MEM_BYTES];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rd_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rd_q;
endmodule

[src/ebac_regfile.sv]
// Sixteen 16-bit scratch registers, one read and one write port, reset to zero.
module ebac_regfile import ebac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  raddr,
	output logic [15:0] rdata,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [15:0] wdata
);
	logic [15:0]         mem_q [NUM_REGS];
	logic [15:0]         rd_q;
	logic [NUM_REGS-1:0] valid_q;
	logic                rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rd_q : 16'h0000;
endmodule

[src/ebac_alu.sv]
// Accumulator arithmetic, logic and shifts for the 7x and Fx groups.
module ebac_alu import ebac_pkg::*; (
	input  logic [7:0] opc,
	input  logic [7:0] d,
	input  logic [7:0] m,
	input  logic       df,
	output logic [7:0] d_nx,
	output logic       df_nx
);
	logic       withc;
	logic       cin_add;
	logic       cin_sub;
	logic [8:0] sum;

	assign withc   = (opc[7:4] == 4'h7);
	assign cin_add = withc ? df : 1'b0;
	assign cin_sub = withc ? df : 1'b1;

	always_comb begin
		sum   = 9'd0;
		d_nx  = d;
		df_nx = df;
		case (opc[2:0])
			3'd0: d_nx = m;
			3'd1: d_nx = d | m;
			3'd2: d_nx = d & m;
			3'd3: d_nx = d ^ m;
			3'd4: begin
				sum = {1'b0, d} + {1'b0, m} + {8'd0, cin_add};
				{df_nx, d_nx} = sum;
			end
			3'd5: begin
				sum = {1'b0, m} + {1'b0, ~d} + {8'd0, cin_sub};
				{df_nx, d_nx} = sum;
			end
			3'd6: begin
				if (opc[3]) begin
					d_nx  = {d[6:0], withc & df};
					df_nx = d[7];
				end else begin
					d_nx  = {withc & df, d[7:1]};
					df_nx = d[0];
				end
			end
			3'd7: begin
				sum = {1'b0, d} + {1'b0, ~m} + {8'd0, cin_sub};
				{df_nx, d_nx} = sum;
			end
			default: d_nx = d;
		endcase
	end
endmodule

[src/ebac_checker.sv]
// Port-level checker for the accumulator core and its bind.
`include "eight_bit_accumulator_cpu_defines.svh"

module ebac_checker import ebac_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);
	`EBAC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
	`EBAC_ASSERT_IMP(a_no_take_held, rsp_valid && !rsp_ready, !cmd_ready, "item taken while result stalled")
	`EBAC_ASSERT_IMP(a_port_idle, rsp_valid && !rsp.port_valid, rsp.port_num == 3'd0 && rsp.port_data == 8'd0, "port fields set without OUT")
	`EBAC_ASSERT_IMP(a_port_op, rsp_valid && rsp.port_valid, rsp.instr[7:4] == 4'h6 && rsp.port_num == rsp.instr[2:0] && rsp.port_num != 3'd0, "port result not from an OUT opcode")
endmodule

bind eight_bit_accumulator_cpu ebac_checker u_ebac_checker (.*);

[sim/eight_bit_accumulator_cpu_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the accumulator core: directed table plus random programs.
module eight_bit_accumulator_cpu_tb;
	import ebac_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;   // unused command code
	localparam logic [7:0] OPC_IDL  = 8'h00;
	localparam logic [7:0] OPC_OUT1 = 8'h61;
	localparam logic [7:0] OPC_REQ  = 8'h7A;
	localparam logic [7:0] OPC_SEQ  = 8'h7B;
	localparam logic [7:0] OPC_ADCI = 8'h7C;
	localparam int MAX_CYCLES = 600000;
	localparam int N_ITEMS    = 1300;

	typedef struct {
		cmd_t c;
		bit   typed;   // expected result given in the row
		rsp_t r;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	eight_bit_accumulator_cpu u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #10 clk = ~clk;

	// Architectural copy of the core, advanced once per accepted item.
	logic [15:0] cpu_r [16];
	logic [7:0]  cpu_d, cpu_t;
	logic        cpu_df, cpu_ie, cpu_q, cpu_idle;
	logic [3:0]  cpu_p, cpu_x;
	logic [7:0]  cpu_mem [MEM_BYTES];
	bit          mem_seen [MEM_BYTES];   // bytes written so far

	rsp_t pending_rsp [$];
	int   n_fail = 0;
	int   n_rsp = 0;
	int   n_exec = 0;
	int   n_out = 0;
	int   n_sent = 0;
	int   cycles = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	vec_t dir_tab [$];

	function automatic logic [7:0] mem_at(logic [15:0] a);
		return cpu_mem[a % MEM_BYTES];
	endfunction

	function automatic void mem_put(logic [15:0] a, logic [7:0] v);
		cpu_mem[a % MEM_BYTES] = v;
		mem_seen[a % MEM_BYTES] = 1'b1;
	endfunction

	function automatic logic [7:0] fetch_pc();
		logic [7:0] v;
		v = mem_at(cpu_r[cpu_p]);
		cpu_r[cpu_p] = cpu_r[cpu_p] + 16'd1;
		return v;
	endfunction

	function automatic void add9(logic [7:0] a, logic [7:0] b, logic cin);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
		cpu_d = s[7:0];
		cpu_df = s[8];
	endfunction

	// Subtract as add of the complement; DF high means no borrow.
	function automatic void sub9(logic [7:0] a, logic [7:0] b, logic cin);
		add9(a, ~b, cin);
	endfunction

	function automatic logic cond_met(logic [2:0] sel, logic [3:0] ef);
		case (sel)
			3'd0: return 1'b1;
			3'd1: return cpu_q;
			3'd2: return cpu_d == 8'd0;
			3'd3: return cpu_df;
			default: return ef[sel[1:0]];
		endcase
	endfunction

	function automatic void run_opcode(logic [7:0] opc, logic [3:0] ef, logic [7:0] inb,
			inout rsp_t r);
		logic [3:0] n;
		logic [3:0] xi;
		logic [7:0] v, h, l;
		logic       go;
		n = opc[3:0];
		xi = cpu_x;
		case (opc[7:4])
			4'h0: begin
				if (n == 4'd0) cpu_idle = 1'b1;
				else cpu_d = mem_at(cpu_r[n]);
			end
			4'h1: cpu_r[n] = cpu_r[n] + 16'd1;
			4'h2: cpu_r[n] = cpu_r[n] - 16'd1;
			4'h3: begin
				go = cond_met(n[2:0], ef) ^ n[3];
				// short branch keeps the page of the operand byte's predecessor
				if (go)
					cpu_r[cpu_p] = ((cpu_r[cpu_p] - 16'd1) & 16'hFF00)
						| {8'd0, mem_at(cpu_r[cpu_p])};
				else
					cpu_r[cpu_p] = cpu_r[cpu_p] + 16'd1;
			end
			4'h4: begin
				cpu_d = mem_at(cpu_r[n]);
				cpu_r[n] = cpu_r[n] + 16'd1;
			end
			4'h5: mem_put(cpu_r[n], cpu_d);
			4'h6: begin
				if (n == 4'd0) begin
					cpu_r[xi] = cpu_r[xi] + 16'd1;
				end else if (n <= 4'd7) begin
					r.port_valid = 1'b1;
					r.port_num = n[2:0];
					r.port_data = mem_at(cpu_r[xi]);
					cpu_r[xi] = cpu_r[xi] + 16'd1;
				end else if (n >= 4'd9) begin
					mem_put(cpu_r[xi], inb);
					cpu_d = inb;
				end
			end
			4'h7: begin
				case (n)
					4'h0, 4'h1: begin
						v = mem_at(cpu_r[xi]);
						cpu_r[xi] = cpu_r[xi] + 16'd1;
						cpu_p = v[3:0];
						cpu_x = v[7:4];
						cpu_ie = (n == 4'h0);
					end
					4'h2: begin
						cpu_d = mem_at(cpu_r[xi]);
						cpu_r[xi] = cpu_r[xi] + 16'd1;
					end
					4'h3: begin
						mem_put(cpu_r[xi], cpu_d);
						cpu_r[xi] = cpu_r[xi] - 16'd1;
					end
					4'h4: add9(cpu_d, mem_at(cpu_r[xi]), cpu_df);
					4'h5: sub9(mem_at(cpu_r[xi]), cpu_d, cpu_df);
					4'h6: begin
						v = {7'd0, cpu_d[0]};
						cpu_d = {cpu_df, cpu_d[7:1]};
						cpu_df = v[0];
					end
					4'h7: sub9(cpu_d, mem_at(cpu_r[xi]), cpu_df);
					4'h8: mem_put(cpu_r[xi], cpu_t);
					4'h9: cpu_t = {cpu_x, cpu_p};
					4'hA: cpu_q = 1'b0;
					4'hB: cpu_q = 1'b1;
					4'hC: add9(cpu_d, fetch_pc(), cpu_df);
					4'hD: sub9(fetch_pc(), cpu_d, cpu_df);
					4'hE: begin
						v = {7'd0, cpu_d[7]};
						cpu_d = {cpu_d[6:0], cpu_df};
						cpu_df = v[0];
					end
					default: sub9(cpu_d, fetch_pc(), cpu_df);
				endcase
			end
			4'h8: cpu_d = cpu_r[n][7:0];
			4'h9: cpu_d = cpu_r[n][15:8];
			4'hA: cpu_r[n][7:0] = cpu_d;
			4'hB: cpu_r[n][15:8] = cpu_d;
			4'hC: begin
				go = 1'b1;   // skip two bytes unless decided otherwise
				if (n == 4'd4) begin
					go = 1'b0;
				end else if (n <= 4'd3 || (n >= 4'd8 && n <= 4'hB)) begin
					if (cond_met({1'b0, n[1:0]}, ef) ^ n[3]) begin
						h = mem_at(cpu_r[cpu_p]);
						l = mem_at(cpu_r[cpu_p] + 16'd1);
						cpu_r[cpu_p] = {h, l};
						go = 1'b0;
					end
				end else if (n <= 4'd7) begin
					go = !cond_met({1'b0, n[1:0]}, ef);
				end else if (n == 4'hC) begin
					go = cpu_ie;
				end else begin
					go = cond_met({1'b0, n[1:0]}, ef);
				end
				if (go) cpu_r[cpu_p] = cpu_r[cpu_p] + 16'd2;
			end
			4'hD: cpu_p = n;
			4'hE: cpu_x = n;
			default: begin
				case (n)
					4'h0: cpu_d = mem_at(cpu_r[xi]);
					4'h1: cpu_d = cpu_d | mem_at(cpu_r[xi]);
					4'h2: cpu_d = cpu_d & mem_at(cpu_r[xi]);
					4'h3: cpu_d = cpu_d ^ mem_at(cpu_r[xi]);
					4'h4: add9(cpu_d, mem_at(cpu_r[xi]), 1'b0);
					4'h5: sub9(mem_at(cpu_r[xi]), cpu_d, 1'b1);
					4'h6: begin
						cpu_df = cpu_d[0];
						cpu_d = {1'b0, cpu_d[7:1]};
					end
					4'h7: sub9(cpu_d, mem_at(cpu_r[xi]), 1'b1);
					4'h8: cpu_d = fetch_pc();
					4'h9: cpu_d = cpu_d | fetch_pc();
					4'hA: cpu_d = cpu_d & fetch_pc();
					4'hB: cpu_d = cpu_d ^ fetch_pc();
					4'hC: add9(cpu_d, fetch_pc(), 1'b0);
					4'hD: sub9(fetch_pc(), cpu_d, 1'b1);
					4'hE: begin
						cpu_df = cpu_d[7];
						cpu_d = {cpu_d[6:0], 1'b0};
					end
					default: sub9(cpu_d, fetch_pc(), 1'b1);
				endcase
			end
		endcase
	endfunction

	// Advance the core copy by one item and return the result it should give.
	function automatic rsp_t next_state(cmd_t c);
		rsp_t r;
		logic [7:0] opc;
		r = '0;
		if (c.op == OP_EXEC) begin
			if (!cpu_idle) begin
				opc = fetch_pc();
				r.instr = opc;
				n_exec++;
				run_opcode(opc, c.ext_flags, c.in_port, r);
				if (r.port_valid) n_out++;
			end
		end else if (c.op == OP_WRITE) begin
			mem_put(c.addr, c.wdata);
		end else if (c.op == OP_SETPC) begin
			cpu_r[cpu_p] = c.addr;
			cpu_idle = 1'b0;
		end
		r.idle = cpu_idle;
		r.q_pin = cpu_q;
		r.int_enable = cpu_ie;
		return r;
	endfunction

	// Drive one item: hold valid and payload until the core takes it.
	task automatic send(cmd_t c, bit typed, rsp_t typed_rsp);
		rsp_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		r = next_state(c);
		n_sent++;
		pending_rsp.push_back(typed ? typed_rsp : r);
	endtask

	// Write a random byte where none has been written yet.
	task automatic touch(logic [15:0] a);
		cmd_t w;
		if (!mem_seen[a % MEM_BYTES]) begin
			w = '0;
			w.op = OP_WRITE;
			w.addr = a;
			w.wdata = 8'($urandom_range(255));
			send(w, 1'b0, '0);
		end
	endtask

	// Before an instruction runs, fill every byte it may read.
	task automatic prime(cmd_t c);
		logic [15:0] pc;
		logic [7:0]  opc;
		if (c.op == OP_EXEC && !cpu_idle) begin
			pc = cpu_r[cpu_p];
			touch(pc);
			opc = mem_at(pc);
			touch(pc + 16'd1);
			touch(pc + 16'd2);
			touch(cpu_r[cpu_x]);
			touch(cpu_r[opc[3:0]]);
		end
	endtask

	task automatic issue(cmd_t c, bit typed, rsp_t typed_rsp);
		prime(c);
		send(c, typed, typed_rsp);
	endtask

	task automatic add_row(logic [1:0] op, logic [15:0] a, logic [7:0] wd, bit typed,
			rsp_t r);
		vec_t v;
		v.c = '0;
		v.c.op = op;
		v.c.addr = a;
		v.c.wdata = wd;
		v.c.ext_flags = 4'hF;
		v.c.in_port = 8'hFF;
		v.typed = typed;
		v.r = r;
		dir_tab.push_back(v);
	endtask

	function automatic rsp_t mk_rsp(logic [7:0] instr, logic idl, logic q);
		rsp_t r;
		r = '0;
		r.instr = instr;
		r.idle = idl;
		r.q_pin = q;
		return r;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		c = '0;
		c.addr = 16'($urandom_range(16'hFFFF));
		c.wdata = 8'($urandom_range(8'hFF));
		c.ext_flags = 4'($urandom_range(4'hF));
		c.in_port = 8'($urandom_range(8'hFF));
		pick = $urandom_range(99);
		// mostly execute; random memory contents make the programs random
		if (pick < 72) c.op = OP_EXEC;
		else if (pick < 87) c.op = OP_WRITE;
		else if (pick < 96) c.op = OP_SETPC;
		else c.op = OP_NONE;
		return c;
	endfunction

	task automatic check_field(string nm, logic [7:0] exp_v, logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, nm, exp_v, got_v);
			n_fail++;
		end
	endtask

	// Result side: random stalls, compare each result against the oldest expectation.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_rsp++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result, got %h", $time, rsp);
				n_fail++;
			end else begin
				e = pending_rsp.pop_front();
				check_field("instr", e.instr, rsp.instr);
				check_field("idle", e.idle, rsp.idle);
				check_field("q_pin", e.q_pin, rsp.q_pin);
				check_field("port_valid", e.port_valid, rsp.port_valid);
				check_field("port_num", e.port_num, rsp.port_num);
				check_field("port_data", e.port_data, rsp.port_data);
				check_field("int_enable", e.int_enable, rsp.int_enable);
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: fail the run on a global cycle limit, whether or not the core is still making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_rsp.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int w;
		for (int i = 0; i < 16; i++) cpu_r[i] = '0;
		for (int i = 0; i < MEM_BYTES; i++) cpu_mem[i] = '0;
		cpu_d = '0; cpu_t = '0; cpu_df = 0; cpu_ie = 0; cpu_q = 0; cpu_idle = 0;
		cpu_p = '0; cpu_x = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed program: SEQ, OUT 1, IDL, ADCI, REQ; then idle, wrap and extremes.
		add_row(OP_NONE, 16'hFFFF, 8'hFF, 1'b1, mk_rsp(8'h00, 1'b0, 1'b0));
		add_row(OP_WRITE, 16'h0000, OPC_SEQ, 1'b1, mk_rsp(8'h00, 1'b0, 1'b0));
		add_row(OP_WRITE, 16'h0001, OPC_OUT1, 1'b0, '0);
		add_row(OP_WRITE, 16'h0002, 8'hFF, 1'b0, '0);
		add_row(OP_WRITE, 16'h0003, OPC_IDL, 1'b0, '0);
		add_row(OP_SETPC, 16'h0000, 8'h00, 1'b1, mk_rsp(8'h00, 1'b0, 1'b0));
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b1, mk_rsp(OPC_SEQ, 1'b0, 1'b1));
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b0, '0);
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b1, mk_rsp(OPC_IDL, 1'b1, 1'b1));
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b1, mk_rsp(8'h00, 1'b1, 1'b1));
		add_row(OP_WRITE, 16'h0004, OPC_ADCI, 1'b1, mk_rsp(8'h00, 1'b1, 1'b1));
		add_row(OP_WRITE, 16'h0005, 8'hFF, 1'b1, mk_rsp(8'h00, 1'b1, 1'b1));
		add_row(OP_WRITE, 16'h0006, OPC_REQ, 1'b1, mk_rsp(8'h00, 1'b1, 1'b1));
		add_row(OP_SETPC, 16'h0004, 8'h00, 1'b1, mk_rsp(8'h00, 1'b0, 1'b1));
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b1, mk_rsp(OPC_ADCI, 1'b0, 1'b1));
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b1, mk_rsp(OPC_REQ, 1'b0, 1'b0));
		add_row(OP_SETPC, 16'hFFFF, 8'h00, 1'b1, mk_rsp(8'h00, 1'b0, 1'b0));
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b0, '0);
		add_row(OP_WRITE, 16'hFFFF, 8'hFF, 1'b0, '0);
		add_row(OP_EXEC, 16'h0000, 8'h00, 1'b0, '0);
		foreach (dir_tab[i]) issue(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);

		// Random part in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 68 : 0;
			recv_stall_pct = (ph == 0) ? 68 : (ph == 1) ? 14 : 0;
			while (n_sent < (ph + 1) * N_ITEMS / 3) issue(rand_cmd(), 1'b0, '0);
		end
		cmd_valid <= 1'b0;
		recv_stall_pct = 0;

		w = 0;
		while (pending_rsp.size() != 0 && w < 10000) begin
			@(posedge clk);
			w++;
		end
		repeat (10) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0d expected results never arrived", pending_rsp.size());
			n_fail++;
		end

		$display("Checked %0d results from %0d items: %0d instructions executed, %0d port writes.",
			n_rsp, n_sent, n_exec, n_out);
		$display("Covered program loading, idle/wake, wraparound and three stall mixes.");
		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/ebac_pkg.sv
src/ebac_memory.sv
src/ebac_regfile.sv
src/ebac_alu.sv
src/eight_bit_accumulator_cpu.sv
src/ebac_checker.sv
sim/eight_bit_accumulator_cpu_tb.sv
